// ----- hdl/pure_pursuit_steering_macros.svh -----
// Assertion helpers for the steering block.
// Both expect clk and arst_n to be in scope.
`ifndef PURE_PURSUIT_STEERING_MACROS_SVH
`define PURE_PURSUIT_STEERING_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pps_pkg.sv -----
`timescale 1ns / 1ps
package pps_pkg;
	localparam int MAX_POINTS_DEF = 1024;

	localparam int CFG_W   = 31;
	localparam int CIDX_W  = 3;
	localparam int IDXO_W  = 10;
	localparam int TAG_W   = 5;
	localparam int DVD_W   = 80;
	localparam int DSR_W   = 64;
	localparam int STEP_W  = 7;

	localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd80;
	localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd31;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_LA_MIN = 3'd0;
	localparam logic [CIDX_W-1:0] REG_LA_MAX = 3'd1;
	localparam logic [CIDX_W-1:0] REG_LA_DIV = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GAIN   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_LIMIT  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_SPEED  = 3'd5;

	localparam logic [CFG_W-1:0] RST_LA_MIN = 31'd19661;
	localparam logic [CFG_W-1:0] RST_LA_MAX = 31'd131072;
	localparam logic [CFG_W-1:0] RST_LA_DIV = 31'd393216;
	localparam logic [CFG_W-1:0] RST_GAIN   = 31'd25559;
	localparam logic [CFG_W-1:0] RST_LIMIT  = 31'd45752;
	localparam logic [CFG_W-1:0] RST_SPEED  = 31'd851968;

	typedef struct packed {
		logic             go;
		logic [TAG_W-1:0] tag;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} ds_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_rsp_t;
endpackage

// ----- hdl/pure_pursuit_steering.sv -----
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// cfg       | cfg_write                 | cfg_index, cfg_data
// item      | item_valid / item_stall   | action, path_start, pos_*, quat_*, shift_*
// result    | result_valid / result_stall | steering, speed, target_index, nearest_index
//
// An odometry transaction's run time grows with N, the stored waypoints, and
// S, the segments walked; the shared 33x33 multiplier, the one-bit-per-cycle
// divide/root unit and the single read port of the path memory set it.
// Reset clears control state and the fill count; the path memory is not cleared.
// item_stall is high while an odometry transaction is in work or its result
// waits for the output register; result_stall holds the output register.
`include "pure_pursuit_steering_macros.svh"
module pure_pursuit_steering #(
	parameter int MAX_POINTS = pps_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pps_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [pps_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               action,
	input  logic                               path_start,
	input  logic signed [31:0]                 pos_x,
	input  logic signed [31:0]                 pos_y,
	input  logic signed [15:0]                 quat_w,
	input  logic signed [15:0]                 quat_x,
	input  logic signed [15:0]                 quat_y,
	input  logic signed [15:0]                 quat_z,
	input  logic signed [31:0]                 shift_x,
	input  logic signed [31:0]                 shift_y,
	input  logic signed [31:0]                 shift_z,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [31:0]                 steering,
	output logic [pps_pkg::CFG_W-1:0]          speed,
	output logic [pps_pkg::IDXO_W-1:0]         target_index,
	output logic [pps_pkg::IDXO_W-1:0]         nearest_index
);
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int ACC_W = 32 + IW;
	localparam int NPROD = 19;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_LA    = 5'd1;
	localparam logic [4:0] ST_LA_W  = 5'd2;
	localparam logic [4:0] ST_LA_D  = 5'd3;
	localparam logic [4:0] ST_LA_DW = 5'd4;
	localparam logic [4:0] ST_N_RD  = 5'd5;
	localparam logic [4:0] ST_N_DIF = 5'd6;
	localparam logic [4:0] ST_N_MX  = 5'd7;
	localparam logic [4:0] ST_N_MY  = 5'd8;
	localparam logic [4:0] ST_N_W   = 5'd9;
	localparam logic [4:0] ST_W_RD0 = 5'd10;
	localparam logic [4:0] ST_W_LD0 = 5'd11;
	localparam logic [4:0] ST_W_TST = 5'd12;
	localparam logic [4:0] ST_W_DIF = 5'd13;
	localparam logic [4:0] ST_W_MX  = 5'd14;
	localparam logic [4:0] ST_W_MY  = 5'd15;
	localparam logic [4:0] ST_W_W   = 5'd16;
	localparam logic [4:0] ST_W_SQ  = 5'd17;
	localparam logic [4:0] ST_QMUL  = 5'd18;
	localparam logic [4:0] ST_RMAT  = 5'd19;
	localparam logic [4:0] ST_PMUL  = 5'd20;
	localparam logic [4:0] ST_CAR   = 5'd21;
	localparam logic [4:0] ST_SQ    = 5'd22;
	localparam logic [4:0] ST_R2    = 5'd23;
	localparam logic [4:0] ST_D_W   = 5'd24;
	localparam logic [4:0] ST_FIN   = 5'd25;

	// product slots
	localparam logic [4:0] TG_RP  = 5'd9;
	localparam logic [4:0] TG_SQX = 5'd15;
	localparam logic [4:0] TG_SQY = 5'd16;
	localparam logic [4:0] TG_SQZ = 5'd17;
	localparam logic [4:0] TG_AUX = 5'd18;

	localparam logic [4:0] QMUL_N = 5'd9;
	localparam logic [4:0] PMUL_N = 5'd6;
	localparam logic [4:0] SQ_N   = 5'd4;

	localparam logic signed [35:0] ONE_Q28 = 36'sh0_1000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			sat32 = 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// configuration
	logic [pps_pkg::CFG_W-1:0] la_min_q, la_max_q, la_div_q, gain_q, limit_q, cmd_speed_q;
	logic [pps_pkg::CFG_W-1:0] last_speed_q;
	logic [CW-1:0]             count_q;

	logic [4:0] state_q;
	logic [4:0] k_q;

	// path memory, {y, x}
	logic [63:0] path_mem [MAX_POINTS];
	logic [63:0] rd_data_q;
	logic        rd_en;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [CW-1:0] wr_idx;

	// working registers
	logic signed [31:0] car_x_q, car_y_q, sx_q, sy_q, sz_q;
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic [pps_pkg::CFG_W-1:0] la_q;
	logic [IW-1:0]      i_q, near_q, lp_q, nx_q;
	logic [64:0]        best_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [31:0] prev_x_q, prev_y_q;
	logic [ACC_W-1:0]   acc_q;
	logic [31:0]        seg_q;
	logic               seg_big_q;
	logic [63:0]        prod_q [NPROD];
	logic signed [29:0] r00_q, r01_q, r10_q, r11_q, r20_q, r21_q;
	logic signed [31:0] xc_q, yc_q, zc_q;
	logic [31:0]        ym_q;
	logic signed [31:0] steer_r_q;

	logic                                out_vld_q;
	logic signed [31:0]                  steer_q;
	logic [pps_pkg::CFG_W-1:0]           speed_q;
	logic [pps_pkg::IDXO_W-1:0]          tgt_q, nrst_q;

	// shared multiplier
	pps_pkg::mul_req_t         mul_req;
	logic signed [32:0]        mul_a, mul_b;
	logic                      mul_vld_s1;
	logic [pps_pkg::TAG_W-1:0] mul_tag_s1;
	logic signed [65:0]        mul_p_s1;

	// divide / root unit
	pps_pkg::ds_req_t           ds_req;
	pps_pkg::ds_rsp_t           ds_rsp;
	logic [pps_pkg::DVD_W-1:0]  ds_dvd;
	logic [pps_pkg::DSR_W-1:0]  ds_dsr;
	logic [pps_pkg::CFG_W-1:0]  ds_cap;
	logic [31:0]                ds_res;

	logic               item_acc;
	logic               out_take;
	logic               fin_load;
	logic [64:0]        dsum;
	logic               dsum_big;
	logic               near_last;
	logic [IW-1:0]      nx_next;
	logic               walk_done;
	logic [ACC_W-1:0]   acc_next;
	logic [63:0]        r2_sum;
	logic [pps_pkg::CFG_W-1:0] la_div_v, la_lo;
	logic signed [35:0] a00, a01, a10, a11, a20, a21;
	logic signed [63:0] xs, ys, zs;

	pps_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.vld_s1 (mul_vld_s1),
		.tag_s1 (mul_tag_s1),
		.p_s1   (mul_p_s1)
	);

	pps_dsu u_dsu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ds_req),
		.dividend (ds_dvd),
		.divisor  (ds_dsr),
		.cap      (ds_cap),
		.rsp      (ds_rsp),
		.res      (ds_res)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign out_take     = out_vld_q && !result_stall;
	assign fin_load     = (state_q == ST_FIN) && (!out_vld_q || !result_stall);
	assign result_valid = out_vld_q;
	assign steering      = steer_q;
	assign speed         = speed_q;
	assign target_index  = tgt_q;
	assign nearest_index = nrst_q;

	assign wr_idx = path_start ? '0 : count_q;
	assign mem_we = item_acc && !action && (wr_idx < CW'(MAX_POINTS));

	// squared distance: first term stored, second still in the multiplier output
	assign dsum     = {1'b0, prod_q[TG_SQX]} + {1'b0, mul_p_s1[63:0]};
	assign dsum_big = dsum[64] | dsum[63] | dsum[62];
	assign near_last = ((CW'(i_q) + CW'(1)) == count_q);
	assign nx_next   = ((CW'(lp_q) + CW'(1)) >= count_q) ? '0 : lp_q + IW'(1);
	assign acc_next  = acc_q + (seg_big_q ? ACC_W'(seg_q) : ACC_W'(ds_res));
	assign walk_done = (acc_q >= ACC_W'(la_q));
	assign r2_sum    = prod_q[TG_SQX] + prod_q[TG_SQY] + prod_q[TG_SQZ];

	assign la_div_v = ds_res[pps_pkg::CFG_W-1:0];
	assign la_lo    = (la_div_v < la_min_q) ? la_min_q : la_div_v;

	always_comb begin
		a00 = ((36'($signed(prod_q[0][31:0])) + 36'($signed(prod_q[1][31:0]))) <<< 1) - ONE_Q28;
		a01 = (36'($signed(prod_q[3][31:0])) - 36'($signed(prod_q[4][31:0]))) <<< 1;
		a10 = (36'($signed(prod_q[3][31:0])) + 36'($signed(prod_q[4][31:0]))) <<< 1;
		a11 = ((36'($signed(prod_q[0][31:0])) + 36'($signed(prod_q[2][31:0]))) <<< 1) - ONE_Q28;
		a20 = (36'($signed(prod_q[5][31:0])) - 36'($signed(prod_q[6][31:0]))) <<< 1;
		a21 = (36'($signed(prod_q[7][31:0])) + 36'($signed(prod_q[8][31:0]))) <<< 1;
		xs = ($signed(prod_q[TG_RP])      + $signed(prod_q[TG_RP + 5'd1])
			+ 64'($signed({sx_q, 24'b0}))) >>> 24;
		ys = ($signed(prod_q[TG_RP + 5'd2]) + $signed(prod_q[TG_RP + 5'd3])
			+ 64'($signed({sy_q, 24'b0}))) >>> 24;
		zs = ($signed(prod_q[TG_RP + 5'd4]) + $signed(prod_q[TG_RP + 5'd5])
			+ 64'($signed({sz_q, 24'b0}))) >>> 24;
	end

	// multiplier operand selection
	always_comb begin
		mul_req.go  = 1'b0;
		mul_req.tag = TG_AUX;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ST_LA: begin
				mul_req.go = (la_div_q != '0);
				mul_a      = {2'b00, la_max_q};
				mul_b      = {2'b00, last_speed_q};
			end
			ST_N_MX, ST_W_MX: begin
				mul_req.go  = 1'b1;
				mul_req.tag = TG_SQX;
				mul_a       = dx_q;
				mul_b       = dx_q;
			end
			ST_N_MY, ST_W_MY: begin
				mul_req.go  = 1'b1;
				mul_req.tag = TG_SQY;
				mul_a       = dy_q;
				mul_b       = dy_q;
			end
			ST_QMUL: begin
				mul_req.go  = (k_q < QMUL_N);
				mul_req.tag = k_q;
				case (k_q)
					5'd0: begin mul_a = 33'(qw_q); mul_b = 33'(qw_q); end
					5'd1: begin mul_a = 33'(qx_q); mul_b = 33'(qx_q); end
					5'd2: begin mul_a = 33'(qy_q); mul_b = 33'(qy_q); end
					5'd3: begin mul_a = 33'(qx_q); mul_b = 33'(qy_q); end
					5'd4: begin mul_a = 33'(qw_q); mul_b = 33'(qz_q); end
					5'd5: begin mul_a = 33'(qx_q); mul_b = 33'(qz_q); end
					5'd6: begin mul_a = 33'(qw_q); mul_b = 33'(qy_q); end
					5'd7: begin mul_a = 33'(qy_q); mul_b = 33'(qz_q); end
					default: begin mul_a = 33'(qw_q); mul_b = 33'(qx_q); end
				endcase
			end
			ST_PMUL: begin
				mul_req.go  = (k_q < PMUL_N);
				mul_req.tag = TG_RP + k_q;
				case (k_q)
					5'd0: begin mul_a = 33'(r00_q); mul_b = 33'(prev_x_q); end
					5'd1: begin mul_a = 33'(r01_q); mul_b = 33'(prev_y_q); end
					5'd2: begin mul_a = 33'(r10_q); mul_b = 33'(prev_x_q); end
					5'd3: begin mul_a = 33'(r11_q); mul_b = 33'(prev_y_q); end
					5'd4: begin mul_a = 33'(r20_q); mul_b = 33'(prev_x_q); end
					default: begin mul_a = 33'(r21_q); mul_b = 33'(prev_y_q); end
				endcase
			end
			ST_SQ: begin
				mul_req.go  = (k_q < SQ_N);
				mul_req.tag = TG_SQX + k_q;
				case (k_q)
					5'd0: begin mul_a = 33'(xc_q); mul_b = 33'(xc_q); end
					5'd1: begin mul_a = 33'(yc_q); mul_b = 33'(yc_q); end
					5'd2: begin mul_a = 33'(zc_q); mul_b = 33'(zc_q); end
					default: begin
						mul_a = {2'b00, gain_q};
						mul_b = {1'b0, ym_q};
					end
				endcase
			end
			default: begin
				mul_req.go = 1'b0;
			end
		endcase
	end

	// divide / root requests
	always_comb begin
		ds_req.start     = 1'b0;
		ds_req.sqrt_mode = 1'b0;
		ds_dvd           = {16'b0, prod_q[TG_AUX]};
		ds_dsr           = {33'b0, la_div_q};
		ds_cap           = la_max_q;
		case (state_q)
			ST_LA_D: begin
				ds_req.start = 1'b1;
			end
			ST_W_W: begin
				ds_req.start     = !dsum_big;
				ds_req.sqrt_mode = 1'b1;
				ds_dvd           = {18'b0, dsum[61:0]};
			end
			ST_R2: begin
				ds_req.start = (r2_sum != '0);
				ds_dvd       = {prod_q[TG_AUX][62:0], 17'b0};
				ds_dsr       = r2_sum;
				ds_cap       = limit_q;
			end
			default: begin
				ds_req.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q;
		case (state_q)
			ST_N_RD: begin
				rd_en = 1'b1;
			end
			ST_W_RD0: begin
				rd_en   = 1'b1;
				rd_addr = near_q;
			end
			ST_W_TST: begin
				rd_en   = !walk_done;
				rd_addr = nx_next;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			path_mem[wr_idx[IW-1:0]] <= {pos_y, pos_x};
		end
		if (rd_en) begin
			rd_data_q <= path_mem[rd_addr];
		end
	end

	// control: sequencer, fill count, configuration, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= '0;
			count_q      <= '0;
			last_speed_q <= '0;
			out_vld_q    <= 1'b0;
			la_min_q     <= pps_pkg::RST_LA_MIN;
			la_max_q     <= pps_pkg::RST_LA_MAX;
			la_div_q     <= pps_pkg::RST_LA_DIV;
			gain_q       <= pps_pkg::RST_GAIN;
			limit_q      <= pps_pkg::RST_LIMIT;
			cmd_speed_q  <= pps_pkg::RST_SPEED;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					pps_pkg::REG_LA_MIN: la_min_q    <= cfg_data;
					pps_pkg::REG_LA_MAX: la_max_q    <= cfg_data;
					pps_pkg::REG_LA_DIV: la_div_q    <= cfg_data;
					pps_pkg::REG_GAIN:   gain_q      <= cfg_data;
					pps_pkg::REG_LIMIT:  limit_q     <= cfg_data;
					pps_pkg::REG_SPEED:  cmd_speed_q <= cfg_data;
					default: ;
				endcase
			end

			if (fin_load) begin
				out_vld_q    <= 1'b1;
				last_speed_q <= cmd_speed_q;
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc && !action) begin
						count_q <= mem_we ? wr_idx + CW'(1) : wr_idx;
					end
					if (item_acc && action && count_q != '0) begin
						state_q <= ST_LA;
					end
				end
				ST_LA: begin
					state_q <= (la_div_q == '0) ? ST_N_RD : ST_LA_W;
				end
				ST_LA_W:  state_q <= ST_LA_D;
				ST_LA_D:  state_q <= ST_LA_DW;
				ST_LA_DW: begin
					if (ds_rsp.done) begin
						state_q <= ST_N_RD;
					end
				end
				ST_N_RD:  state_q <= ST_N_DIF;
				ST_N_DIF: state_q <= ST_N_MX;
				ST_N_MX:  state_q <= ST_N_MY;
				ST_N_MY:  state_q <= ST_N_W;
				ST_N_W:   state_q <= near_last ? ST_W_RD0 : ST_N_RD;
				ST_W_RD0: state_q <= ST_W_LD0;
				ST_W_LD0: state_q <= ST_W_TST;
				ST_W_TST: begin
					k_q     <= '0;
					state_q <= walk_done ? ST_QMUL : ST_W_DIF;
				end
				ST_W_DIF: state_q <= ST_W_MX;
				ST_W_MX:  state_q <= ST_W_MY;
				ST_W_MY:  state_q <= ST_W_W;
				ST_W_W:   state_q <= ST_W_SQ;
				ST_W_SQ: begin
					if (seg_big_q || ds_rsp.done) begin
						k_q     <= '0;
						state_q <= (nx_q == near_q) ? ST_QMUL : ST_W_TST;
					end
				end
				ST_QMUL: begin
					k_q <= k_q + 5'd1;
					if (k_q == QMUL_N) begin
						k_q     <= '0;
						state_q <= ST_RMAT;
					end
				end
				ST_RMAT: state_q <= ST_PMUL;
				ST_PMUL: begin
					k_q <= k_q + 5'd1;
					if (k_q == PMUL_N) begin
						k_q     <= '0;
						state_q <= ST_CAR;
					end
				end
				ST_CAR: state_q <= ST_SQ;
				ST_SQ: begin
					k_q <= k_q + 5'd1;
					if (k_q == SQ_N) begin
						k_q     <= '0;
						state_q <= ST_R2;
					end
				end
				ST_R2:  state_q <= (r2_sum == '0) ? ST_FIN : ST_D_W;
				ST_D_W: begin
					if (ds_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_vld_s1) begin
			prod_q[mul_tag_s1] <= mul_p_s1[63:0];
		end
		if (fin_load) begin
			steer_q <= steer_r_q;
			speed_q <= cmd_speed_q;
			tgt_q   <= pps_pkg::IDXO_W'(lp_q);
			nrst_q  <= pps_pkg::IDXO_W'(near_q);
		end
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					car_x_q <= pos_x;
					car_y_q <= pos_y;
					qw_q    <= quat_w;
					qx_q    <= quat_x;
					qy_q    <= quat_y;
					qz_q    <= quat_z;
					sx_q    <= shift_x;
					sy_q    <= shift_y;
					sz_q    <= shift_z;
					i_q     <= '0;
				end
			end
			ST_LA: begin
				la_q <= la_max_q;
			end
			ST_LA_DW: begin
				if (ds_rsp.done) begin
					la_q <= (la_lo > la_max_q) ? la_max_q : la_lo;
				end
			end
			ST_N_DIF: begin
				dx_q <= 33'($signed(rd_data_q[31:0])) - 33'(car_x_q);
				dy_q <= 33'($signed(rd_data_q[63:32])) - 33'(car_y_q);
			end
			ST_N_W: begin
				if (i_q == '0 || dsum < best_q) begin
					best_q <= dsum;
					near_q <= i_q;
				end
				i_q <= i_q + IW'(1);
			end
			ST_W_RD0: begin
				lp_q  <= near_q;
				acc_q <= '0;
			end
			ST_W_LD0: begin
				prev_x_q <= $signed(rd_data_q[31:0]);
				prev_y_q <= $signed(rd_data_q[63:32]);
			end
			ST_W_TST: begin
				nx_q <= nx_next;
			end
			ST_W_DIF: begin
				dx_q     <= 33'(prev_x_q) - 33'($signed(rd_data_q[31:0]));
				dy_q     <= 33'(prev_y_q) - 33'($signed(rd_data_q[63:32]));
				prev_x_q <= $signed(rd_data_q[31:0]);
				prev_y_q <= $signed(rd_data_q[63:32]);
			end
			ST_W_W: begin
				seg_big_q <= dsum_big;
				seg_q     <= 32'h8000_0000;
			end
			ST_W_SQ: begin
				if (seg_big_q || ds_rsp.done) begin
					acc_q <= acc_next;
					lp_q  <= nx_q;
				end
			end
			ST_RMAT: begin
				r00_q <= 30'(a00 >>> 4);
				r01_q <= 30'(a01 >>> 4);
				r10_q <= 30'(a10 >>> 4);
				r11_q <= 30'(a11 >>> 4);
				r20_q <= 30'(a20 >>> 4);
				r21_q <= 30'(a21 >>> 4);
			end
			ST_CAR: begin
				xc_q <= sat32(xs);
				yc_q <= sat32(ys);
				zc_q <= sat32(zs);
			end
			ST_SQ: begin
				if (k_q == '0) begin
					ym_q <= yc_q[31] ? (~$unsigned(yc_q) + 32'd1) : $unsigned(yc_q);
				end
			end
			ST_R2: begin
				steer_r_q <= '0;
			end
			ST_D_W: begin
				if (ds_rsp.done) begin
					steer_r_q <= yc_q[31] ? $signed(~ds_res + 32'd1) : $signed(ds_res);
				end
			end
			default: ;
		endcase
	end

	`PPS_ASSERT_IMP(a_near_in_path, (state_q == ST_W_TST), (CW'(near_q) < count_q), "nearest index beyond stored path")
	`PPS_ASSERT_IMP(a_dsu_owner, ds_rsp.busy, (state_q == ST_LA_DW || state_q == ST_W_SQ || state_q == ST_D_W), "divide unit busy outside a wait state")
	`PPS_ASSERT_NXT(a_empty_drop, (item_acc && action && count_q == '0), (state_q == ST_IDLE && !fin_load), "odometry on empty path started work")
endmodule

// ----- hdl/pps_mul.sv -----
`timescale 1ns / 1ps
module pps_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pps_pkg::mul_req_t            req,
	input  logic signed [32:0]           a,
	input  logic signed [32:0]           b,
	output logic                         vld_s1,
	output logic [pps_pkg::TAG_W-1:0]    tag_s1,
	output logic signed [65:0]           p_s1
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			tag_s1 <= req.tag;
			p_s1   <= a * b;
		end
	end
endmodule

// ----- hdl/pps_dsu.sv -----
`timescale 1ns / 1ps
// One bit per cycle: restoring divide with saturation to cap, or integer square root.
module pps_dsu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pps_pkg::ds_req_t              req,
	input  logic [pps_pkg::DVD_W-1:0]     dividend,
	input  logic [pps_pkg::DSR_W-1:0]     divisor,
	input  logic [pps_pkg::CFG_W-1:0]     cap,
	output pps_pkg::ds_rsp_t              rsp,
	output logic [31:0]                   res
);
	logic                          busy_q;
	logic                          done_q;
	logic                          mode_q;
	logic [pps_pkg::STEP_W-1:0]    cnt_q;
	logic [pps_pkg::DVD_W-1:0]     dvd_q;
	logic [pps_pkg::DSR_W-1:0]     dsr_q;
	logic [pps_pkg::DSR_W-1:0]     rem_q;
	logic [31:0]                   quo_q;
	logic                          big_q;
	logic [pps_pkg::CFG_W-1:0]     cap_q;

	logic [64:0] cmp_a;
	logic [64:0] cmp_b;
	logic [64:0] diff;
	logic        ge;

	always_comb begin
		if (mode_q) begin
			cmp_a = {1'b0, rem_q[61:0], dvd_q[79:78]};
			cmp_b = {32'b0, quo_q[30:0], 2'b01};
		end else begin
			cmp_a = {rem_q, dvd_q[79]};
			cmp_b = {1'b0, dsr_q};
		end
		ge   = (cmp_a >= cmp_b);
		diff = cmp_a - cmp_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.sqrt_mode;
				cnt_q  <= req.sqrt_mode ? pps_pkg::SQRT_STEPS : pps_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.sqrt_mode ? {dividend[61:0], 18'b0} : dividend;
			dsr_q <= divisor;
			cap_q <= cap;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= mode_q ? {dvd_q[77:0], 2'b00} : {dvd_q[78:0], 1'b0};
			rem_q <= ge ? diff[63:0] : cmp_a[63:0];
			quo_q <= {quo_q[30:0], ge};
			big_q <= big_q | quo_q[31];
		end
	end

	always_comb begin
		if (mode_q) begin
			res = quo_q;
		end else if (big_q || quo_q > {1'b0, cap_q}) begin
			res = {1'b0, cap_q};
		end else begin
			res = quo_q;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
endmodule
